[design/dpt_pkg.sv]
`default_nettype none

package dpt_pkg;

	localparam int DEVICES_DEFAULT = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int QUEUE_DEPTH     = 2;

	localparam int ADDR_W   = 48;
	localparam int TIME_W   = 32;
	localparam int ACTION_W = 2;
	localparam int KIND_W   = 3;
	localparam int SLOT_W   = 4;
	localparam int REG_IDX_W = 1;
	localparam int OP_W     = 3;

	localparam logic [TIME_W-1:0] TIMEOUT_MAINS_RESET   = 32'd90000;
	localparam logic [TIME_W-1:0] TIMEOUT_BATTERY_RESET = 32'd600000;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_MAINS   = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_BATTERY = 1'd1;

	// input actions
	localparam logic [ACTION_W-1:0] ACT_HELLO = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_STATE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_EVENT = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd3;

	// classified commands handed to the table walker
	localparam logic [OP_W-1:0] OP_HELLO     = 3'd0;
	localparam logic [OP_W-1:0] OP_HELLO_BAD = 3'd1;
	localparam logic [OP_W-1:0] OP_STATE     = 3'd2;
	localparam logic [OP_W-1:0] OP_EVENT     = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK      = 3'd4;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_STATE         = 3'd0;
	localparam logic [KIND_W-1:0] KIND_EVENT         = 3'd1;
	localparam logic [KIND_W-1:0] KIND_HELLO_NEW     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_HELLO_REFRESH = 3'd3;
	localparam logic [KIND_W-1:0] KIND_OFFLINE       = 3'd4;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN       = 3'd5;
	localparam logic [KIND_W-1:0] KIND_FULL          = 3'd6;
	localparam logic [KIND_W-1:0] KIND_INVALID       = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] addr;
		logic              battery;
		logic [TIME_W-1:0] now;
	} cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0] mains;
		logic [TIME_W-1:0] battery;
	} timeouts_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              battery;
		logic              online;
		logic [TIME_W-1:0] contact;
	} entry_t;

	// handshake between the command queue and the walker
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

endpackage

`default_nettype wire

[design/dpt_front.sv]
`default_nettype none

module dpt_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [dpt_pkg::ACTION_W-1:0]  action,
	input  wire logic [dpt_pkg::ADDR_W-1:0]    sender_address,
	input  wire logic                          battery_powered,
	input  wire logic                          id_valid,
	input  wire logic [dpt_pkg::TIME_W-1:0]    now_ms,
	output dpt_pkg::queue_head_t               head,
	input  wire logic                          pop
);
	import dpt_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	cmd_t             cmd;
	logic             push;
	logic             do_pop;

	always_comb begin
		cmd.addr    = sender_address;
		cmd.battery = battery_powered;
		cmd.now     = now_ms;
		unique case (action)
			ACT_HELLO: cmd.op = id_valid ? OP_HELLO : OP_HELLO_BAD;
			ACT_STATE: cmd.op = OP_STATE;
			ACT_EVENT: cmd.op = OP_EVENT;
			ACT_TICK:  cmd.op = OP_TICK;
			default:   cmd.op = OP_TICK;
		endcase
	end

	assign item_stall = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign push       = item_valid && !item_stall;
	assign do_pop     = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[design/dpt_back.sv]
`default_nettype none

module dpt_back #(
	parameter int DEVICES = dpt_pkg::DEVICES_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dpt_pkg::queue_head_t        head,
	output logic                             pop,
	input  wire dpt_pkg::timeouts_t          timeouts,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic [dpt_pkg::KIND_W-1:0]       kind,
	output logic [dpt_pkg::SLOT_W-1:0]       slot,
	output logic                             came_online,
	output logic                             last
);
	import dpt_pkg::*;

	localparam int IDX_W   = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam int COUNT_W = $clog2(DEVICES + 1);
	localparam int N_W     = $clog2(MAX_RESULTS + 1);
	localparam int EXT_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_EMIT  = 2'd2;

	entry_t             entry_mem_q [DEVICES];
	entry_t             rdata_q;
	logic [1:0]         state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [COUNT_W-1:0] count_q;
	cmd_t               cmd_q;
	logic [KIND_W-1:0]  res_kind_q;
	logic [IDX_W-1:0]   res_slot_q;
	logic               res_online_q;
	logic               pend_q;
	logic [N_W-1:0]     n_q;

	logic               out_valid_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic               out_online_q;
	logic               out_last_q;

	logic               out_free;
	logic               match;
	logic               is_end;
	logic               full;
	logic               room;
	logic [TIME_W-1:0]  limit;
	logic [TIME_W-1:0]  elapsed;
	logic               expire;
	logic               tick_wait;
	logic [IDX_W-1:0]   idx_next;
	logic [IDX_W-1:0]   append_idx;

	logic               rd_en;
	logic [IDX_W-1:0]   raddr;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	entry_t             wdata;

	logic               out_load;
	logic [KIND_W-1:0]  out_kind_d;
	logic               out_last_d;
	logic [EXT_W-1:0]   slot_ext;

	assign out_free   = !out_valid_q || !result_stall;
	assign match      = (rdata_q.addr == cmd_q.addr);
	assign is_end     = (COUNT_W'(idx_q) == count_q - COUNT_W'(1));
	assign full       = (count_q == COUNT_W'(DEVICES));
	assign room       = (n_q < N_W'(MAX_RESULTS));
	assign limit      = rdata_q.battery ? timeouts.battery : timeouts.mains;
	assign elapsed    = cmd_q.now - rdata_q.contact;
	assign expire     = rdata_q.online && (elapsed > limit);
	// a new expiry pushes the held one out, so it waits for the output register
	assign tick_wait  = expire && room && pend_q && !out_free;
	assign idx_next   = idx_q + IDX_W'(1);
	assign append_idx = count_q[IDX_W-1:0];
	assign pop        = (state_q == S_IDLE) && head.valid;

	always_comb begin
		rd_en = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata_q;
		unique case (state_q)
			S_IDLE: begin
				if (head.valid && head.cmd.op != OP_HELLO_BAD) begin
					if (count_q == '0) begin
						if (head.cmd.op == OP_HELLO) begin
							we            = 1'b1;
							waddr         = '0;
							wdata.addr    = head.cmd.addr;
							wdata.battery = head.cmd.battery;
							wdata.online  = 1'b1;
							wdata.contact = head.cmd.now;
						end
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			S_CHECK: begin
				if (cmd_q.op != OP_TICK) begin
					if (match) begin
						we            = 1'b1;
						wdata.contact = cmd_q.now;
						if (cmd_q.op != OP_EVENT) begin
							wdata.online = 1'b1;
						end
					end else if (is_end) begin
						if (cmd_q.op == OP_HELLO && !full) begin
							we            = 1'b1;
							waddr         = append_idx;
							wdata.addr    = cmd_q.addr;
							wdata.battery = cmd_q.battery;
							wdata.online  = 1'b1;
							wdata.contact = cmd_q.now;
						end
					end else begin
						rd_en = 1'b1;
						raddr = idx_next;
					end
				end else if (!tick_wait) begin
					if (expire) begin
						we           = 1'b1;
						wdata.online = 1'b0;
					end
					if (!is_end) begin
						rd_en = 1'b1;
						raddr = idx_next;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			entry_mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= entry_mem_q[raddr];
		end
	end

	always_comb begin
		out_load   = 1'b0;
		out_kind_d = res_kind_q;
		out_last_d = 1'b1;
		if (state_q == S_EMIT) begin
			out_load = out_free;
		end else if (state_q == S_CHECK && cmd_q.op == OP_TICK) begin
			if (expire && room && pend_q && out_free) begin
				out_load   = 1'b1;
				out_kind_d = KIND_OFFLINE;
				out_last_d = 1'b0;
			end
		end
	end

	assign slot_ext = EXT_W'(res_slot_q);

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q   <= out_kind_d;
			out_slot_q   <= slot_ext[SLOT_W-1:0];
			out_online_q <= res_online_q;
			out_last_q   <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// working command and result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (head.valid) begin
					cmd_q        <= head.cmd;
					res_slot_q   <= '0;
					res_online_q <= 1'b0;
					if (head.cmd.op == OP_HELLO_BAD) begin
						res_kind_q <= KIND_INVALID;
					end else if (head.cmd.op == OP_HELLO) begin
						res_kind_q <= KIND_HELLO_NEW;
					end else begin
						res_kind_q <= KIND_UNKNOWN;
					end
				end
			end
			S_CHECK: begin
				if (cmd_q.op != OP_TICK) begin
					if (match) begin
						res_slot_q <= idx_q;
						if (cmd_q.op == OP_HELLO) begin
							res_kind_q <= KIND_HELLO_REFRESH;
						end else if (cmd_q.op == OP_STATE) begin
							res_kind_q   <= KIND_STATE;
							res_online_q <= !rdata_q.online;
						end else begin
							res_kind_q <= KIND_EVENT;
						end
					end else if (is_end) begin
						if (cmd_q.op != OP_HELLO) begin
							res_kind_q <= KIND_UNKNOWN;
						end else if (full) begin
							res_kind_q <= KIND_FULL;
						end else begin
							res_kind_q <= KIND_HELLO_NEW;
							res_slot_q <= append_idx;
						end
					end
				end else if (!tick_wait && expire && room) begin
					res_kind_q <= KIND_OFFLINE;
					res_slot_q <= idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						idx_q  <= '0;
						pend_q <= 1'b0;
						n_q    <= '0;
						if (head.cmd.op == OP_HELLO_BAD) begin
							state_q <= S_EMIT;
						end else if (count_q == '0) begin
							if (head.cmd.op == OP_HELLO) begin
								count_q <= COUNT_W'(1);
								state_q <= S_EMIT;
							end else if (head.cmd.op != OP_TICK) begin
								state_q <= S_EMIT;
							end
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (cmd_q.op != OP_TICK) begin
						if (match) begin
							state_q <= S_EMIT;
						end else if (is_end) begin
							if (cmd_q.op == OP_HELLO && !full) begin
								count_q <= count_q + COUNT_W'(1);
							end
							state_q <= S_EMIT;
						end else begin
							idx_q <= idx_next;
						end
					end else if (!tick_wait) begin
						if (expire && room) begin
							pend_q <= 1'b1;
							n_q    <= n_q + N_W'(1);
						end
						if (is_end) begin
							state_q <= (pend_q || (expire && room)) ? S_EMIT : S_IDLE;
						end else begin
							idx_q <= idx_next;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = out_kind_q;
	assign slot         = out_slot_q;
	assign came_online  = out_online_q;
	assign last         = out_last_q;

endmodule

`default_nettype wire

[design/device_presence_table.sv]
`default_nettype none

// Presence table for up to DEVICES senders. Hellos with a valid id find or
// append an entry and mark it online; state and event reports from known
// senders refresh the contact time; a sweep tick takes every online entry
// whose wrapped elapsed time exceeds its power-class timeout offline and
// reports each one in table order (at most 16 reports per tick, the final
// one flagged by last). Items enter a two-deep command queue; the walker
// behind it scans the entry memory (one read and one write port) one entry
// per cycle, but a tick may pause on an expiry while the result side stalls.
// Timeouts are written through wr_en/wr_index/wr_data; the user must do so
// only while the block idles, and the block itself does not enforce this.
module device_presence_table #(
	parameter int DEVICES = dpt_pkg::DEVICES_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [dpt_pkg::REG_IDX_W-1:0]  wr_index,
	input  wire logic [dpt_pkg::TIME_W-1:0]     wr_data,
	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire logic [dpt_pkg::ACTION_W-1:0]   action,
	input  wire logic [dpt_pkg::ADDR_W-1:0]     sender_address,
	input  wire logic                           battery_powered,
	input  wire logic                           id_valid,
	input  wire logic [dpt_pkg::TIME_W-1:0]     now_ms,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output logic [dpt_pkg::KIND_W-1:0]          kind,
	output logic [dpt_pkg::SLOT_W-1:0]          slot,
	output logic                                came_online,
	output logic                                last
);
	import dpt_pkg::*;

	timeouts_t   timeouts_q;
	queue_head_t head;
	logic        pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeouts_q.mains   <= TIMEOUT_MAINS_RESET;
			timeouts_q.battery <= TIMEOUT_BATTERY_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_TIMEOUT_MAINS:   timeouts_q.mains   <= wr_data;
				REG_TIMEOUT_BATTERY: timeouts_q.battery <= wr_data;
				default: begin
				end
			endcase
		end
	end

	dpt_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.action          (action),
		.sender_address  (sender_address),
		.battery_powered (battery_powered),
		.id_valid        (id_valid),
		.now_ms          (now_ms),
		.head            (head),
		.pop             (pop)
	);

	dpt_back #(
		.DEVICES (DEVICES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.timeouts     (timeouts_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.slot         (slot),
		.came_online  (came_online),
		.last         (last)
	);

endmodule

`default_nettype wire

[tb/tb_device_presence_table.sv]
`default_nettype none

module tb_device_presence_table;
	timeunit 1ns;
	timeprecision 1ps;

	import dpt_pkg::*;

	localparam int TABLE_SIZE   = DEVICES_DEFAULT;
	localparam int POOL_SIZE    = 20;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};
	localparam logic [TIME_W-1:0] TIME_ONES = {TIME_W{1'b1}};

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic              came_online;
		logic              last;
	} presence_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [TIME_W-1:0]    wr_data;
	logic                 item_valid;
	logic                 item_stall;
	logic [ACTION_W-1:0]  action;
	logic [ADDR_W-1:0]    sender_address;
	logic                 battery_powered;
	logic                 id_valid;
	logic [TIME_W-1:0]    now_ms;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [KIND_W-1:0]    kind;
	logic [SLOT_W-1:0]    slot;
	logic                 came_online;
	logic                 last;

	// predicted table contents
	logic [ADDR_W-1:0] tbl_addr [TABLE_SIZE];
	logic              tbl_battery [TABLE_SIZE];
	logic              tbl_online [TABLE_SIZE];
	logic [TIME_W-1:0] tbl_contact [TABLE_SIZE];
	int                tbl_count;
	logic [TIME_W-1:0] limit_mains;
	logic [TIME_W-1:0] limit_battery;

	presence_result_t  expected_results[$];
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
	logic [TIME_W-1:0] clock_ms;

	int fail_count;
	int items_sent;
	int results_seen;
	int kind_seen [8];
	int cycle_count;
	int burst_left;
	int sender_gap_max;
	int stall_mode;
	int stall_run;
	int stall_tick;

	device_presence_table u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.action          (action),
		.sender_address  (sender_address),
		.battery_powered (battery_powered),
		.id_valid        (id_valid),
		.now_ms          (now_ms),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.kind            (kind),
		.slot            (slot),
		.came_online     (came_online),
		.last            (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void add_expected(logic [KIND_W-1:0] k, int idx, logic back,
			logic fin);
		presence_result_t r;
		r.kind        = k;
		r.slot        = SLOT_W'(idx);
		r.came_online = back;
		r.last        = fin;
		expected_results.push_back(r);
	endfunction

	function automatic int find_entry(logic [ADDR_W-1:0] addr);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_addr[i] == addr)
				return i;
		return -1;
	endfunction

	function automatic bit entry_expires(int i, logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] lim;
		logic [TIME_W-1:0] elapsed;
		lim     = tbl_battery[i] ? limit_battery : limit_mains;
		elapsed = now - tbl_contact[i];
		return tbl_online[i] && (elapsed > lim);
	endfunction

	function automatic void predict_item(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr,
			logic batt, logic idv, logic [TIME_W-1:0] now);
		int idx;
		int expiries;
		int k;
		logic back;
		case (act)
			ACT_HELLO: begin
				idx = find_entry(addr);
				if (!idv) begin
					add_expected(KIND_INVALID, 0, 1'b0, 1'b1);
				end else if (idx < 0 && tbl_count >= TABLE_SIZE) begin
					add_expected(KIND_FULL, 0, 1'b0, 1'b1);
				end else begin
					if (idx < 0) begin
						idx = tbl_count;
						tbl_count++;
						tbl_addr[idx]    = addr;
						tbl_battery[idx] = batt;
						add_expected(KIND_HELLO_NEW, idx, 1'b0, 1'b1);
					end else begin
						// the stored power class survives a refresh
						add_expected(KIND_HELLO_REFRESH, idx, 1'b0, 1'b1);
					end
					tbl_contact[idx] = now;
					tbl_online[idx]  = 1'b1;
				end
			end
			ACT_STATE, ACT_EVENT: begin
				idx = find_entry(addr);
				if (idx < 0) begin
					add_expected(KIND_UNKNOWN, 0, 1'b0, 1'b1);
				end else begin
					tbl_contact[idx] = now;
					if (act == ACT_STATE) begin
						back = !tbl_online[idx];
						tbl_online[idx] = 1'b1;
						add_expected(KIND_STATE, idx, back, 1'b1);
					end else begin
						add_expected(KIND_EVENT, idx, 1'b0, 1'b1);
					end
				end
			end
			default: begin
				expiries = 0;
				for (int i = 0; i < tbl_count; i++)
					if (entry_expires(i, now))
						expiries++;
				if (expiries > MAX_RESULTS)
					expiries = MAX_RESULTS;
				k = 0;
				for (int i = 0; i < tbl_count; i++) begin
					if (entry_expires(i, now)) begin
						tbl_online[i] = 1'b0;
						if (k < MAX_RESULTS)
							add_expected(KIND_OFFLINE, i, 1'b0, k == expiries - 1);
						k++;
					end
				end
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- result side

	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run  = $urandom_range(20, 200);
		end else begin
			stall_run--;
		end
		stall_tick++;
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 99) < 30);
			2: result_stall <= ($urandom_range(0, 99) < 75);
			default: result_stall <= (stall_tick % 5) < 2;
		endcase
	end

	always @(posedge clk) begin : check_results
		presence_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			kind_seen[kind]++;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: kind %0d slot %0d", kind, slot);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					fail_count++;
				end
				if (slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, slot);
					fail_count++;
				end
				if (came_online !== want.came_online) begin
					$error("came_online: expected %0d, got %0d", want.came_online, came_online);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sender side

	task automatic send_item(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr, logic batt,
			logic idv, logic [TIME_W-1:0] now);
		int gap;
		if (burst_left == 0) begin
			gap        = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				item_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		item_valid      <= 1'b1;
		action          <= act;
		sender_address  <= addr;
		battery_powered <= batt;
		id_valid        <= idv;
		now_ms          <= now;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predict_item(act, addr, batt, idv, now);
		items_sent++;
	endtask

	task automatic idle_sender();
		@(negedge clk);
		item_valid <= 1'b0;
		burst_left = 0;
	endtask

	// hold off until every predicted result is in, then let any silent tick finish
	task automatic drain_results();
		idle_sender();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_timeouts(logic [TIME_W-1:0] mains, logic [TIME_W-1:0] batt);
		drain_results();
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= REG_TIMEOUT_MAINS;
		wr_data  <= mains;
		@(negedge clk);
		wr_index <= REG_TIMEOUT_BATTERY;
		wr_data  <= batt;
		@(negedge clk);
		wr_en <= 1'b0;
		limit_mains   = mains;
		limit_battery = batt;
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_empty_table();
		send_item(ACT_TICK, ADDR_ONES, 1'b1, 1'b1, '0);
		send_item(ACT_STATE, '0, 1'b0, 1'b1, TIME_ONES);
		send_item(ACT_EVENT, ADDR_ONES, 1'b1, 1'b0, 32'd17);
		send_item(ACT_HELLO, addr_pool[2], 1'b1, 1'b0, 32'd20);
	endtask

	task automatic test_hello_and_reports();
		send_item(ACT_HELLO, '0, 1'b0, 1'b1, '0);
		send_item(ACT_HELLO, ADDR_ONES, 1'b1, 1'b1, TIME_ONES);
		// refresh must not turn the mains entry into a battery one
		send_item(ACT_HELLO, '0, 1'b1, 1'b1, 32'd50);
		send_item(ACT_STATE, '0, 1'b0, 1'b0, 32'd60);
		send_item(ACT_EVENT, ADDR_ONES, 1'b0, 1'b0, 32'd70);
	endtask

	task automatic test_aging();
		send_item(ACT_STATE, '0, 1'b0, 1'b0, 32'd100);
		send_item(ACT_EVENT, ADDR_ONES, 1'b0, 1'b0, 32'd100);
		send_item(ACT_TICK, '0, 1'b0, 1'b0, 32'd90100);
		send_item(ACT_TICK, '0, 1'b0, 1'b0, 32'd90101);
		send_item(ACT_TICK, '0, 1'b0, 1'b0, 32'd600101);
		send_item(ACT_STATE, '0, 1'b0, 1'b0, 32'd600200);
		send_item(ACT_EVENT, ADDR_ONES, 1'b0, 1'b0, 32'd600300);
		// contact just below the wrap, sweep just after it
		send_item(ACT_STATE, ADDR_ONES, 1'b0, 1'b0, 32'hFFFF_FF00);
		send_item(ACT_TICK, '0, 1'b0, 1'b0, 32'h0000_0100);
	endtask

	task automatic test_timeout_extremes();
		set_timeouts('0, '0);
		send_item(ACT_HELLO, '0, 1'b0, 1'b1, 32'd5000);
		send_item(ACT_TICK, '0, 1'b0, 1'b0, 32'd5000);
		send_item(ACT_TICK, '0, 1'b0, 1'b0, 32'd5001);
		set_timeouts(TIME_ONES, TIME_ONES);
		send_item(ACT_STATE, '0, 1'b0, 1'b0, 32'd7);
		send_item(ACT_TICK, '0, 1'b0, 1'b0, 32'd6);
	endtask

	task automatic test_random_traffic(int count, logic [TIME_W-1:0] mains,
			logic [TIME_W-1:0] batt, int step_max, int gap_max);
		int pick;
		logic [ACTION_W-1:0] act;
		logic [ADDR_W-1:0]   addr;
		set_timeouts(mains, batt);
		sender_gap_max = gap_max;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				act = ACT_HELLO;
			else if (pick < 55)
				act = ACT_STATE;
			else if (pick < 75)
				act = ACT_EVENT;
			else
				act = ACT_TICK;
			if ($urandom_range(0, 99) < 85)
				addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				addr = {16'($urandom), 32'($urandom)};
			if ($urandom_range(0, 19) == 0)
				clock_ms = $urandom;
			else
				clock_ms += $urandom_range(0, step_max);
			if (n == count / 2)
				drain_results();
			send_item(act, addr, 1'($urandom), $urandom_range(0, 9) != 0, clock_ms);
		end
	endtask

	// ---------------------------------------------------------------- run

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			expected_results.size());
		$display("** device_presence_table: FAILED **");
		$finish;
	end

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = REG_TIMEOUT_MAINS;
		wr_data         = '0;
		item_valid      = 1'b0;
		action          = ACT_HELLO;
		sender_address  = '0;
		battery_powered = 1'b0;
		id_valid        = 1'b0;
		now_ms          = '0;
		tbl_count       = 0;
		limit_mains     = TIMEOUT_MAINS_RESET;
		limit_battery   = TIMEOUT_BATTERY_RESET;
		clock_ms        = '0;
		fail_count      = 0;
		items_sent      = 0;
		results_seen    = 0;
		burst_left      = 0;
		sender_gap_max  = 3;
		stall_mode      = 0;
		stall_run       = 0;
		stall_tick      = 0;
		foreach (kind_seen[i])
			kind_seen[i] = 0;
		addr_pool[0] = '0;
		addr_pool[1] = ADDR_ONES;
		for (int i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = {16'($urandom), 32'($urandom)};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_hello_and_reports();
		test_aging();
		test_timeout_extremes();
		test_random_traffic(60, TIMEOUT_MAINS_RESET, TIMEOUT_BATTERY_RESET, 200000, 4);
		test_random_traffic(80, 32'd1000, 32'd5000, 3000, 0);
		test_random_traffic(80, '0, TIME_ONES, 50, 6);
		test_random_traffic(80, TIME_ONES, '0, 40, 2);
		test_random_traffic(80, $urandom_range(0, 2000), $urandom_range(0, 8000), 4000, 5);
		test_random_traffic(60, TIMEOUT_MAINS_RESET, TIMEOUT_BATTERY_RESET, 150000, 3);

		drain_results();
		$display("%0d items in, %0d results out, %0d of %0d entries in use", items_sent,
			results_seen, tbl_count, TABLE_SIZE);
		$display("kinds seen: state %0d event %0d new %0d refresh %0d offline %0d",
			kind_seen[KIND_STATE], kind_seen[KIND_EVENT], kind_seen[KIND_HELLO_NEW],
			kind_seen[KIND_HELLO_REFRESH], kind_seen[KIND_OFFLINE]);
		if (fail_count == 0)
			$display("** device_presence_table: PASSED **");
		else
			$display("** device_presence_table: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
